>>> sv/fbaff_pkg.sv
package fbaff_pkg;

  localparam int unsigned UW = 15;

  typedef logic [UW-1:0] unit_t;

  typedef struct packed {
    logic  valid;
    unit_t base;
    unit_t length;
  } entry_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BADREL = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic CFG_FIT_POLICY = 1'b0;

endpackage

>>> sv/fbaff_if.sv
interface fbaff_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [14:0] block_size;
  logic [14:0] block_address;
  logic [15:0] request_tag;

  modport source (output valid, opcode, block_size, block_address, request_tag,
                  input ready);
  modport sink (input valid, opcode, block_size, block_address, request_tag,
                output ready);
endinterface

interface fbaff_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] grant_address;
  logic [15:0] tag_echo;

  modport source (output valid, status, grant_address, tag_echo, input ready);
  modport sink (input valid, status, grant_address, tag_echo, output ready);
endinterface

>>> sv/fbaff_mem.sv
module fbaff_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  fbaff_pkg::entry_t        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output fbaff_pkg::entry_t        rdata
);
  import fbaff_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/free_block_allocator_first_best_fit.sv
// After a request is accepted, its result comes from one pass over the extent memory at one
// entry read per cycle, a decision state, up to two write-back states and the output register
// load; a failed request skips the write-back. Requests rejected on their fields alone go
// straight to the output register load. The next request is taken the cycle after the
// result is loaded, and a stalled result holds it off. After reset a clearing pass
// initialises the extent memory, taking no request; configuration writes are still taken.
module free_block_allocator_first_best_fit #(
  parameter int unsigned ARENA_SIZE       = 32767,
  parameter int unsigned MAX_FREE_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  fbaff_req_if.sink   req,
  fbaff_rsp_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbaff_pkg::*;

  localparam int unsigned IW = $clog2(MAX_FREE_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_FREE_EXTENTS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_FREE_EXTENTS - 1);
  localparam logic [CW-1:0] ENDC = CW'(MAX_FREE_EXTENTS);
  localparam logic [UW:0] ARENA_W = (UW+1)'(ARENA_SIZE);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DEC, S_WR1, S_WR2, S_OUT} state_t;

  state_t        state;
  logic          fit_policy;
  logic [CW-1:0] cnt;
  logic          proc_vld;
  logic [IW-1:0] proc_idx;

  logic          op;
  unit_t         size;
  unit_t         addr;
  logic [15:0]   tag;
  logic [UW:0]   rel_end;

  logic          found;
  logic [IW-1:0] pick;
  unit_t         pick_base;
  unit_t         pick_len;
  logic          bad;
  logic          has_left;
  logic [IW-1:0] left_idx;
  unit_t         left_base;
  unit_t         left_len;
  logic          has_right;
  logic [IW-1:0] right_idx;
  unit_t         right_len;
  logic          has_empty;
  logic [IW-1:0] empty_idx;

  logic          two_writes;
  logic [IW-1:0] wr1_idx;
  entry_t        wr1_data;
  logic [1:0]    res_status;
  unit_t         res_grant;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  entry_t        rd;
  logic [UW:0]   rd_end;
  logic          better;

  fbaff_mem #(.DEPTH(MAX_FREE_EXTENTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt[IW-1:0]),
    .rdata (rd)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_FIT_POLICY) ? {31'd0, fit_policy} : 32'd0;

  assign req.ready = (state == S_IDLE);
  assign mem_re    = (state == S_SCAN) && (cnt < ENDC);
  assign rd_end    = {1'b0, rd.base} + {1'b0, rd.length};

  always_comb begin
    if (fit_policy == FIT_FIRST) begin
      better = rd.base < pick_base;
    end else begin
      better = (rd.length < pick_len) || ((rd.length == pick_len) && (rd.base < pick_base));
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr1_idx;
    mem_wdata = wr1_data;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = (cnt == '0) ? '{valid: 1'b1, base: '0, length: UW'(ARENA_SIZE)} : '0;
      end
      S_WR1: mem_we = 1'b1;
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = right_idx;
        mem_wdata = '0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= FIT_FIRST;
    end else if (psel && penable && pwrite && paddr[2] == CFG_FIT_POLICY) begin
      fit_policy <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      proc_vld  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      proc_vld <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op        <= req.opcode;
            size      <= req.block_size;
            addr      <= req.block_address;
            tag       <= req.request_tag;
            rel_end   <= {1'b0, req.block_address} + {1'b0, req.block_size};
            cnt       <= '0;
            found     <= 1'b0;
            bad       <= 1'b0;
            has_left  <= 1'b0;
            has_right <= 1'b0;
            has_empty <= 1'b0;
            res_grant <= '0;
            if (req.block_size == '0) begin
              res_status <= (req.opcode == OP_ALLOC) ? ST_NOFIT : ST_BADREL;
              state      <= S_OUT;
            end else if (req.opcode == OP_RELEASE &&
                         ({1'b0, req.block_address} + {1'b0, req.block_size}) > ARENA_W) begin
              res_status <= ST_BADREL;
              state      <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt < ENDC) begin
            cnt      <= cnt + 1'b1;
            proc_vld <= 1'b1;
            proc_idx <= cnt[IW-1:0];
          end else begin
            state <= S_DEC;
          end
          if (proc_vld) begin
            if (op == OP_ALLOC) begin
              if (rd.valid && rd.length >= size && (!found || better)) begin
                found     <= 1'b1;
                pick      <= proc_idx;
                pick_base <= rd.base;
                pick_len  <= rd.length;
              end
            end else if (!rd.valid) begin
              if (!has_empty) begin
                has_empty <= 1'b1;
                empty_idx <= proc_idx;
              end
            end else begin
              if ({1'b0, addr} < rd_end && {1'b0, rd.base} < rel_end) begin
                bad <= 1'b1;
              end
              if (rd_end == {1'b0, addr}) begin
                has_left  <= 1'b1;
                left_idx  <= proc_idx;
                left_base <= rd.base;
                left_len  <= rd.length;
              end
              if ({1'b0, rd.base} == rel_end) begin
                has_right <= 1'b1;
                right_idx <= proc_idx;
                right_len <= rd.length;
              end
            end
          end
        end
        S_DEC: begin
          two_writes <= 1'b0;
          res_status <= ST_OK;
          state      <= S_WR1;
          if (op == OP_ALLOC) begin
            if (!found) begin
              res_status <= ST_NOFIT;
              state      <= S_OUT;
            end else begin
              res_grant <= pick_base;
              wr1_idx   <= pick;
              if (pick_len == size) begin
                wr1_data <= '0;
              end else begin
                wr1_data <= '{valid: 1'b1, base: UW'(pick_base + size),
                              length: UW'(pick_len - size)};
              end
            end
          end else if (bad) begin
            res_status <= ST_BADREL;
            state      <= S_OUT;
          end else if (has_left) begin
            wr1_idx    <= left_idx;
            two_writes <= has_right;
            wr1_data   <= '{valid: 1'b1, base: left_base,
                            length: has_right ? UW'(left_len + size + right_len)
                                              : UW'(left_len + size)};
          end else if (has_right) begin
            wr1_idx  <= right_idx;
            wr1_data <= '{valid: 1'b1, base: addr, length: UW'(right_len + size)};
          end else if (has_empty) begin
            wr1_idx  <= empty_idx;
            wr1_data <= '{valid: 1'b1, base: addr, length: size};
          end else begin
            res_status <= ST_FULL;
            state      <= S_OUT;
          end
        end
        S_WR1: state <= two_writes ? S_WR2 : S_OUT;
        S_WR2: state <= S_OUT;
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.grant_address <= res_grant;
            rsp.tag_echo      <= tag;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/fbaff_checker.sv
module fbaff_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [14:0] grant_address
);
  import fbaff_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> grant_address == '0)
    else $error("non-zero grant on a failed transaction");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a transaction is in progress");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block ready during initialisation");

endmodule

bind free_block_allocator_first_best_fit fbaff_checker u_fbaff_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .grant_address (rsp.grant_address)
);

>>> tb/sv/tb_free_block_allocator_first_best_fit.sv
`timescale 1ns / 100ps

module tb_free_block_allocator_first_best_fit;
  import fbaff_pkg::*;

  localparam int unsigned ARENA   = 32767;
  localparam int unsigned EXTENTS = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic        opcode;
    logic [14:0] block_size;
    logic [14:0] block_address;
    logic [15:0] request_tag;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] grant_address;
    logic [15:0] tag_echo;
  } grant_t;

  typedef struct {
    request_t rq;
    logic     known;
    grant_t   rs;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fbaff_req_if req ();
  fbaff_rsp_if rsp ();

  free_block_allocator_first_best_fit #(
    .ARENA_SIZE(ARENA),
    .MAX_FREE_EXTENTS(EXTENTS)
  ) i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow of the free extent table.
  logic        policy_shadow;
  logic [31:0] ext_base [EXTENTS];
  logic [31:0] ext_len  [EXTENTS];
  logic        ext_live [EXTENTS];

  grant_t pending_grants[$];
  int     failures = 0;
  int     cycles = 0;
  logic   hold_off = 1'b0;
  logic   long_stall = 1'b0;

  function automatic void shadow_reset();
    policy_shadow = FIT_FIRST;
    for (int i = 0; i < EXTENTS; i++) begin
      ext_base[i] = 0;
      ext_len[i] = 0;
      ext_live[i] = 1'b0;
    end
    ext_len[0] = ARENA;
    ext_live[0] = 1'b1;
  endfunction

  function automatic grant_t allocate_or_release(request_t rq);
    grant_t r;
    int pick, left, right, empty;
    logic [31:0] sz, ad, en, b, e;
    logic bad;
    r.status = ST_OK;
    r.grant_address = '0;
    r.tag_echo = rq.request_tag;
    sz = rq.block_size;
    ad = rq.block_address;
    pick = -1;
    left = -1;
    right = -1;
    empty = -1;
    bad = 1'b0;
    if (rq.opcode == OP_ALLOC) begin
      if (sz == 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      for (int i = 0; i < EXTENTS; i++) begin
        if (ext_live[i] && ext_len[i] >= sz) begin
          if (pick < 0) pick = i;
          else if (policy_shadow == FIT_FIRST) begin
            if (ext_base[i] < ext_base[pick]) pick = i;
          end else if (ext_len[i] < ext_len[pick] ||
                       (ext_len[i] == ext_len[pick] && ext_base[i] < ext_base[pick])) begin
            pick = i;
          end
        end
      end
      if (pick < 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      r.grant_address = ext_base[pick][14:0];
      if (ext_len[pick] == sz) begin
        ext_live[pick] = 1'b0;
        ext_base[pick] = 0;
        ext_len[pick] = 0;
      end else begin
        ext_base[pick] += sz;
        ext_len[pick] -= sz;
      end
      return r;
    end
    en = ad + sz;
    if (sz == 0 || en > ARENA) begin
      r.status = ST_BADREL;
      return r;
    end
    for (int i = 0; i < EXTENTS; i++) begin
      if (!ext_live[i]) begin
        if (empty < 0) empty = i;
      end else begin
        b = ext_base[i];
        e = b + ext_len[i];
        if (ad < e && b < en) bad = 1'b1;
        if (e == ad) left = i;
        if (b == en) right = i;
      end
    end
    if (bad) r.status = ST_BADREL;
    else if (left >= 0 && right >= 0) begin
      ext_len[left] += sz + ext_len[right];
      ext_live[right] = 1'b0;
      ext_base[right] = 0;
      ext_len[right] = 0;
    end else if (left >= 0) ext_len[left] += sz;
    else if (right >= 0) begin
      ext_base[right] = ad;
      ext_len[right] += sz;
    end else if (empty < 0) r.status = ST_FULL;
    else begin
      ext_live[empty] = 1'b1;
      ext_base[empty] = ad;
      ext_len[empty] = sz;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("free_block_allocator_first_best_fit regression: fail");
      $finish;
    end
  end

  // Receiver: a pattern of short stalls, plus one long hold-off that it counts itself.
  initial begin
    int   stall_left;
    logic stall_used;
    stall_left = 0;
    stall_used = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall && !stall_used) begin
        stall_used = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (hold_off) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    grant_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result transaction with no expectation, status %0d", rsp.status);
        failures++;
      end else begin
        exp_r = pending_grants.pop_front();
        if (rsp.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp.status);
          failures++;
        end
        if (rsp.grant_address !== exp_r.grant_address) begin
          $error("grant_address expected %0d actual %0d", exp_r.grant_address,
                 rsp.grant_address);
          failures++;
        end
        if (rsp.tag_echo !== exp_r.tag_echo) begin
          $error("tag_echo expected %0h actual %0h", exp_r.tag_echo, rsp.tag_echo);
          failures++;
        end
      end
    end
  end

  task automatic write_policy(logic value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * CFG_FIT_POLICY);
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    policy_shadow = value;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (2 * EXTENTS + 10) @(posedge clk);
  endtask

  task automatic send(request_t rq, logic known, grant_t fixed);
    grant_t pred;
    req.valid <= 1'b1;
    req.opcode <= rq.opcode;
    req.block_size <= rq.block_size;
    req.block_address <= rq.block_address;
    req.request_tag <= rq.request_tag;
    do @(posedge clk); while (!req.ready);
    pred = allocate_or_release(rq);
    if (known && pred !== fixed) begin
      $error("table row expected %0h predicted %0h", fixed, pred);
      failures++;
    end
    pending_grants.push_back(pred);
  endtask

  task automatic idle_gap();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t rq;
    int kind;
    kind = $urandom_range(0, 99);
    rq.request_tag = 16'($urandom);
    rq.opcode = (kind < 50) ? OP_ALLOC : OP_RELEASE;
    if (kind < 45) begin
      rq.block_size = 15'($urandom_range(1, 600));
      rq.block_address = 15'($urandom);
    end else if (kind < 50) begin
      rq.block_size = 15'($urandom);
      rq.block_address = 15'($urandom);
    end else if (kind < 90) begin
      rq.block_address = 15'($urandom_range(0, ARENA - 1));
      rq.block_size = 15'($urandom_range(1, 200));
    end else begin
      rq.block_address = 15'($urandom);
      rq.block_size = 15'($urandom);
    end
    return rq;
  endfunction

  stim_row_t table_rows[$];

  function automatic stim_row_t row(logic op, int sz, int ad, int tg, logic known,
                                    logic [1:0] st, int ga);
    stim_row_t s;
    s.rq = '{op, 15'(sz), 15'(ad), 16'(tg)};
    s.known = known;
    s.rs = '{st, 15'(ga), 16'(tg)};
    return s;
  endfunction

  initial begin
    request_t rq;
    int burst;
    shadow_reset();
    req.valid = 1'b0;
    req.opcode = OP_ALLOC;
    req.block_size = '0;
    req.block_address = '0;
    req.request_tag = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    table_rows.push_back(row(OP_ALLOC, 0, 0, 16'h0000, 1, ST_NOFIT, 0));
    table_rows.push_back(row(OP_RELEASE, 0, 100, 16'hFFFF, 1, ST_BADREL, 0));
    table_rows.push_back(row(OP_RELEASE, 10, 32760, 16'h1234, 1, ST_BADREL, 0));
    table_rows.push_back(row(OP_RELEASE, 32767, 32767, 16'h5555, 1, ST_BADREL, 0));
    table_rows.push_back(row(OP_RELEASE, 5, 10, 16'h00AA, 1, ST_BADREL, 0));
    table_rows.push_back(row(OP_ALLOC, 100, 32767, 16'h0001, 1, ST_OK, 0));
    table_rows.push_back(row(OP_ALLOC, 50, 0, 16'h0002, 1, ST_OK, 100));
    table_rows.push_back(row(OP_ALLOC, 200, 0, 16'h0003, 1, ST_OK, 150));
    table_rows.push_back(row(OP_ALLOC, 32767, 0, 16'h0004, 1, ST_NOFIT, 0));
    table_rows.push_back(row(OP_RELEASE, 50, 100, 16'h0005, 0, ST_OK, 0));
    table_rows.push_back(row(OP_RELEASE, 100, 0, 16'h0006, 0, ST_OK, 0));
    table_rows.push_back(row(OP_RELEASE, 200, 150, 16'h0007, 0, ST_OK, 0));
    table_rows.push_back(row(OP_ALLOC, 32767, 0, 16'h0008, 1, ST_OK, 0));
    table_rows.push_back(row(OP_RELEASE, 32767, 0, 16'h0009, 0, ST_OK, 0));
    for (int i = 0; i < table_rows.size(); i++) begin
      send(table_rows[i].rq, table_rows[i].known, table_rows[i].rs);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    req.valid <= 1'b0;
    drain();

    // Fragment the arena into many single-unit holes so the table fills up.
    write_policy(FIT_BEST);
    send('{OP_ALLOC, 15'd32767, 15'd0, 16'hABCD}, 1'b0, '0);
    for (int i = 0; i < EXTENTS + 2; i++) begin
      send('{OP_RELEASE, 15'd1, 15'(4 * i), 16'(i)}, 1'b0, '0);
      if (i == 10) long_stall <= 1'b1;
    end
    req.valid <= 1'b0;
    drain();
    send('{OP_ALLOC, 15'd1, 15'd0, 16'h7777}, 1'b0, '0);
    send('{OP_RELEASE, 15'd32767, 15'd0, 16'h8888}, 1'b0, '0);
    req.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 105; n += burst) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          rq = random_request();
          send(rq, 1'b0, '0);
        end
        idle_gap();
      end
      req.valid <= 1'b0;
      hold_off <= (phase == 2);
      drain();
      write_policy(phase[0] ? FIT_FIRST : FIT_BEST);
    end

    drain();
    if (failures == 0) $display("free_block_allocator_first_best_fit regression: pass");
    else $display("free_block_allocator_first_best_fit regression: fail");
    $finish;
  end

endmodule
